[rtl/core/pflc_pkg.sv]
package pflc_pkg;

  localparam int unsigned ELEMENTS_PER_PAGE = 100;
  localparam int unsigned FRAME_COUNT = 4;

  localparam int unsigned INDEX_W = 20;
  localparam int unsigned PAGE_W = 14;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SLOT_OUT_W = 2;
  localparam int unsigned SLOT_W = $clog2(FRAME_COUNT);

  // exact division of an INDEX_W-bit value by a multiply with a rounded-up reciprocal
  localparam int unsigned DIV_SHIFT = INDEX_W + $clog2(ELEMENTS_PER_PAGE);
  localparam int unsigned RECIP_W = INDEX_W + 1;
  localparam int unsigned PROD_W = INDEX_W + RECIP_W;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SHIFT) + ELEMENTS_PER_PAGE - 1) / ELEMENTS_PER_PAGE;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;
  typedef logic [PROD_W-1:0] prod_t;

endpackage

[rtl/core/pflc_req_if.sv]
interface pflc_req_if;
  logic valid;
  logic ready;
  pflc_pkg::index_t element_index;

  modport source(output valid, output element_index, input ready);
  modport sink(input valid, input element_index, output ready);
endinterface

[rtl/core/pflc_rsp_if.sv]
interface pflc_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  pflc_pkg::page_t page_number;
  pflc_pkg::slot_out_t frame_slot;
  logic evicted;
  pflc_pkg::page_t evicted_page;

  modport source(output valid, output hit, output page_number, output frame_slot,
                 output evicted, output evicted_page, input ready);
  modport sink(input valid, input hit, input page_number, input frame_slot,
               input evicted, input evicted_page, output ready);
endinterface

[rtl/core/page_frame_lfu_cache_unit.sv]
// pipeline: an accepted item is registered in the input reg, then in the result reg;
//   a stall on rsp holds it in the input reg until the result reg is taken
// throughput: one item per cycle unless stalled; the reciprocal-multiply page divide,
//   the tag compare, the least-used search and the frame update sit between both regs
// reset: synchronous active-high rst empties the pipeline and marks every frame invalid
//   with tags and use counts at zero
module page_frame_lfu_cache_unit (
  input  logic       clk,
  input  logic       rst,
  pflc_req_if.sink   req,
  pflc_rsp_if.source rsp
);

  localparam int unsigned Frames = pflc_pkg::FRAME_COUNT;

  logic                  s0_valid;
  pflc_pkg::index_t      s0_index;
  logic                  out_valid;
  logic                  out_hit;
  pflc_pkg::page_t       out_page;
  pflc_pkg::slot_out_t   out_slot;
  logic                  out_evicted;
  pflc_pkg::page_t       out_evicted_page;

  pflc_pkg::page_t       frame_page [Frames];
  logic [Frames-1:0]     frame_valid;
  pflc_pkg::count_t      use_count [Frames];

  logic                  out_free;
  logic                  s0_ready;
  logic                  s0_fire;
  pflc_pkg::prod_t       div_prod;
  pflc_pkg::page_t       div_page;

  logic                  hit_found;
  pflc_pkg::slot_t       hit_slot;
  pflc_pkg::count_t      hit_count;
  logic                  empty_found;
  pflc_pkg::slot_t       empty_slot;
  pflc_pkg::slot_t       min_slot;
  pflc_pkg::count_t      min_count;
  pflc_pkg::page_t       min_page;
  pflc_pkg::slot_t       sel_slot;

  assign out_free = !out_valid || rsp.ready;
  assign s0_ready = !s0_valid || out_free;
  assign s0_fire  = s0_valid && out_free;
  assign req.ready = s0_ready;

  assign div_prod = pflc_pkg::prod_t'(s0_index) * pflc_pkg::prod_t'(pflc_pkg::RECIP_VAL);
  // quotient is truncated to the tag width
  assign div_page = pflc_pkg::page_t'(div_prod >> pflc_pkg::DIV_SHIFT);

  always_comb begin
    hit_found   = 1'b0;
    hit_slot    = '0;
    hit_count   = '0;
    empty_found = 1'b0;
    empty_slot  = '0;
    min_slot    = '0;
    min_count   = use_count[0];
    min_page    = frame_page[0];
    for (int i = 0; i < Frames; i++) begin
      if (!hit_found && frame_valid[i] && frame_page[i] == div_page) begin
        hit_found = 1'b1;
        hit_slot  = pflc_pkg::slot_t'(i);
        hit_count = use_count[i];
      end
      if (!empty_found && !frame_valid[i]) begin
        empty_found = 1'b1;
        empty_slot  = pflc_pkg::slot_t'(i);
      end
    end
    // strict compare keeps the lowest slot on a tie
    for (int i = 1; i < Frames; i++) begin
      if (use_count[i] < min_count) begin
        min_slot  = pflc_pkg::slot_t'(i);
        min_count = use_count[i];
        min_page  = frame_page[i];
      end
    end
    if (hit_found) begin
      sel_slot = hit_slot;
    end else if (empty_found) begin
      sel_slot = empty_slot;
    end else begin
      sel_slot = min_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid <= req.valid;
      end
      if (out_free) begin
        out_valid <= s0_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && req.valid) begin
      s0_index <= req.element_index;
    end
    if (s0_fire) begin
      out_hit          <= hit_found;
      out_page         <= div_page;
      out_slot         <= pflc_pkg::slot_out_t'(sel_slot);
      out_evicted      <= !hit_found && !empty_found;
      out_evicted_page <= (!hit_found && !empty_found) ? min_page : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      for (int i = 0; i < Frames; i++) begin
        frame_page[i] <= '0;
        use_count[i]  <= '0;
      end
    end else if (s0_fire) begin
      if (hit_found) begin
        if (hit_count != pflc_pkg::COUNT_MAX) begin
          use_count[hit_slot] <= hit_count + pflc_pkg::count_t'(1);
        end
      end else begin
        frame_page[sel_slot]  <= div_page;
        frame_valid[sel_slot] <= 1'b1;
        use_count[sel_slot]   <= pflc_pkg::count_t'(1);
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.page_number  = out_page;
  assign rsp.frame_slot   = out_slot;
  assign rsp.evicted      = out_evicted;
  assign rsp.evicted_page = out_evicted_page;

  // an eviction never comes with a hit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evicted |-> !out_hit)
    else $error("eviction reported on a hit");

  // evicted page reads zero unless something was evicted
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_evicted |-> out_evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  // eviction only happens once every frame is filled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evicted |-> frame_valid == '1)
    else $error("eviction while a frame was empty");

  // frames only fill up between resets
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(frame_valid) >= $countones($past(frame_valid)))
    else $error("frame valid bit dropped");

endmodule

[verif/lfu_lookup_checker.sv]
module lfu_lookup_checker (
  input  logic       clk,
  input  logic       rst,
  pflc_req_if        req,
  pflc_rsp_if        rsp,
  output int         failures,
  output int         outstanding
);

  typedef struct packed {
    logic                hit;
    pflc_pkg::page_t     page_number;
    pflc_pkg::slot_out_t frame_slot;
    logic                evicted;
    pflc_pkg::page_t     evicted_page;
  } lookup_result_t;

  pflc_pkg::page_t  frame_tag [pflc_pkg::FRAME_COUNT];
  logic             frame_live [pflc_pkg::FRAME_COUNT];
  pflc_pkg::count_t hit_count [pflc_pkg::FRAME_COUNT];
  lookup_result_t   expected_results [$];

  initial failures = 0;

  assign outstanding = expected_results.size();

  task automatic report_error(input string msg);
    failures++;
    $display("[%0t] lfu check: %s", $time, msg);
  endtask

  // resolves one lookup against the frame table and updates it
  function automatic lookup_result_t lookup_page(input pflc_pkg::index_t idx);
    lookup_result_t  r;
    pflc_pkg::page_t pg;
    int unsigned     s;
    logic            found;
    logic            empty;
    r = '0;
    pg = pflc_pkg::page_t'(32'(idx) / pflc_pkg::ELEMENTS_PER_PAGE);
    r.page_number = pg;
    found = 1'b0;
    empty = 1'b0;
    s = 0;
    for (int i = 0; i < pflc_pkg::FRAME_COUNT; i++) begin
      if (!found && frame_live[i] && frame_tag[i] == pg) begin
        found = 1'b1;
        s = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (hit_count[s] != pflc_pkg::COUNT_MAX) hit_count[s] = hit_count[s] + 1'b1;
    end else begin
      for (int i = 0; i < pflc_pkg::FRAME_COUNT; i++) begin
        if (!empty && !frame_live[i]) begin
          empty = 1'b1;
          s = i;
        end
      end
      // table full: least used frame goes, lowest slot on a tie
      if (!empty) begin
        s = 0;
        for (int i = 1; i < pflc_pkg::FRAME_COUNT; i++) begin
          if (hit_count[i] < hit_count[s]) s = i;
        end
        r.evicted = 1'b1;
        r.evicted_page = frame_tag[s];
      end
      frame_tag[s] = pg;
      frame_live[s] = 1'b1;
      hit_count[s] = 1;
    end
    r.frame_slot = pflc_pkg::slot_out_t'(s);
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < pflc_pkg::FRAME_COUNT; i++) begin
        frame_tag[i] = '0;
        frame_live[i] = 1'b0;
        hit_count[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result for page %0d", rsp.page_number));
        end else begin
          want = expected_results.pop_front();
          if (rsp.hit !== want.hit)
            report_error($sformatf("hit %b, want %b (page %0d)",
                                   rsp.hit, want.hit, want.page_number));
          if (rsp.page_number !== want.page_number)
            report_error($sformatf("page_number %0d, want %0d",
                                   rsp.page_number, want.page_number));
          if (rsp.frame_slot !== want.frame_slot)
            report_error($sformatf("frame_slot %0d, want %0d (page %0d)",
                                   rsp.frame_slot, want.frame_slot, want.page_number));
          if (rsp.evicted !== want.evicted)
            report_error($sformatf("evicted %b, want %b (page %0d)",
                                   rsp.evicted, want.evicted, want.page_number));
          if (rsp.evicted_page !== want.evicted_page)
            report_error($sformatf("evicted_page %0d, want %0d (page %0d)",
                                   rsp.evicted_page, want.evicted_page, want.page_number));
        end
      end
      if (req.valid && req.ready) expected_results.push_back(lookup_page(req.element_index));
    end
  end

endmodule

[verif/tb_top.sv]
module tb_top;

  localparam int unsigned MAX_INDEX = (1 << pflc_pkg::INDEX_W) - 1;
  localparam int unsigned MAX_PAGE = MAX_INDEX / pflc_pkg::ELEMENTS_PER_PAGE;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 200;
  localparam int CHUNKS = 7;
  localparam int CHUNK_ITEMS = 150;

  logic clk = 1'b0;
  logic rst;
  int   failures;
  int   outstanding;
  int   cycle_count = 0;
  bit   gaps_on = 1'b1;
  bit   long_hold_req = 1'b0;

  pflc_pkg::index_t directed_idx [16] = '{
    20'd0, 20'd99, 20'd100, 20'd1048575, 20'd1048500, 20'd200, 20'd300, 20'd400,
    20'd250, 20'd499, 20'h55555, 20'hAAAAA, 20'd1048555, 20'h0F0F0, 20'hF0F0F, 20'd1
  };

  pflc_req_if req ();
  pflc_rsp_if rsp ();

  page_frame_lfu_cache_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  lfu_lookup_checker checker_i (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .failures(failures),
    .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_frame_lfu_cache_unit verification failed");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_lookup(input pflc_pkg::index_t idx);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.element_index <= idx;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold so the pipeline backs up
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned      pick;
    int unsigned      pg;
    int unsigned      top_off;
    int unsigned      hot_pages [6];
    pflc_pkg::index_t idx;
    rst = 1'b1;
    req.valid = 1'b0;
    req.element_index = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fills, hits, tie-break evictions, eviction of page 0, top of the index range
    foreach (directed_idx[i]) send_lookup(directed_idx[i]);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      gaps_on = !(chunk == 1 || chunk == 4);
      if (chunk == 4) long_hold_req = 1'b1;
      foreach (hot_pages[p]) hot_pages[p] = $urandom_range(0, MAX_PAGE);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          idx = pflc_pkg::index_t'($urandom_range(0, MAX_INDEX));
        end else begin
          // a few hot pages keep hits, count ordering and evictions going
          pg = (pick < 6) ? hot_pages[$urandom_range(0, 2)] : hot_pages[$urandom_range(0, 5)];
          top_off = (pg == MAX_PAGE) ? MAX_INDEX - pg * pflc_pkg::ELEMENTS_PER_PAGE
                                     : pflc_pkg::ELEMENTS_PER_PAGE - 1;
          idx = pflc_pkg::index_t'(pg * pflc_pkg::ELEMENTS_PER_PAGE +
                                   $urandom_range(0, top_off));
        end
        send_lookup(idx);
      end
    end
    req.valid <= 1'b0;

    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("page_frame_lfu_cache_unit verification clean");
    end else begin
      $display("page_frame_lfu_cache_unit verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/pflc_pkg.sv
rtl/core/pflc_req_if.sv
rtl/core/pflc_rsp_if.sv
rtl/core/page_frame_lfu_cache_unit.sv
verif/lfu_lookup_checker.sv
verif/tb_top.sv
